// File: hdl/rlkg_pkg.sv
package rlkg_pkg;

    // Field and datapath widths
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = SQ_W + 2;
    localparam int LIMIT_W    = DIST_W + 2;
    localparam int NIDX_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int SPACE_W    = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // Cycles from the last scan read until the sorted list has settled
    localparam int DRAIN_CYCLES = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 1'b1;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } pos_t;

    // One scored candidate leaving the distance unit
    typedef struct packed {
        logic              valid;
        logic [NIDX_W-1:0] idx;
        logic [DIST_W-1:0] sq_dist;
    } cand_t;

endpackage

// File: hdl/rlkg_if.sv
// Command channel: loads and queries
interface rlkg_cmd_if import rlkg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [NIDX_W-1:0]         node_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;

    modport source (output valid, op, node_index, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, op, node_index, pos_x, pos_y, pos_z, output ready);
endinterface

// Result channel: one word per neighbor, or one found=0 word when there is none
interface rlkg_rsp_if import rlkg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NIDX_W-1:0] neighbor_index;
    logic              found;
    logic              last;

    modport source (output valid, neighbor_index, found, last, input ready);
    modport sink   (input valid, neighbor_index, found, last, output ready);
endinterface

// File: hdl/rlkg_store.sv
module rlkg_store import rlkg_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pos_t          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output pos_t          rd_data
);

    pos_t mem [DEPTH];

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/rlkg_dist.sv
module rlkg_dist import rlkg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_self,
    input  logic              in_valid,
    input  logic [NIDX_W-1:0] in_idx,
    input  pos_t              in_pos,
    output cand_t             cand
);

    pos_t self_reg;

    logic                     v1_reg, v2_reg, v3_reg;
    logic [NIDX_W-1:0]        i1_reg, i2_reg, i3_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]          sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0]        sum_reg;

    logic signed [DIFF_W-1:0]   dx_next, dy_next, dz_next;
    logic signed [2*DIFF_W-1:0] px, py, pz;

    // Differences against the queried node, sign extended by one bit
    assign dx_next = {self_reg.x[COORD_W-1], self_reg.x} - {in_pos.x[COORD_W-1], in_pos.x};
    assign dy_next = {self_reg.y[COORD_W-1], self_reg.y} - {in_pos.y[COORD_W-1], in_pos.y};
    assign dz_next = {self_reg.z[COORD_W-1], self_reg.z} - {in_pos.z[COORD_W-1], in_pos.z};

    // Squares; magnitude below 2^16 so the square fits 32 bits
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (load_self)
        begin
            self_reg <= in_pos;
        end
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        i1_reg  <= in_idx;
        sx_reg  <= px[SQ_W-1:0];
        sy_reg  <= py[SQ_W-1:0];
        sz_reg  <= pz[SQ_W-1:0];
        i2_reg  <= i1_reg;
        sum_reg <= DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
        i3_reg  <= i2_reg;
    end

    assign cand.valid   = v3_reg;
    assign cand.idx     = i3_reg;
    assign cand.sq_dist = sum_reg;

endmodule

// File: hdl/rlkg_list.sv
module rlkg_list import rlkg_pkg::*; #(
    parameter int NEIGHBORS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  cand_t                cand,
    input  logic [LIMIT_W-1:0]   limit,
    output logic [NIDX_W-1:0]    idx [NEIGHBORS],
    output logic [NEIGHBORS-1:0] pass
);

    logic [NEIGHBORS-1:0] valid_reg, valid_next;
    logic [DIST_W-1:0]    dist_reg [NEIGHBORS];
    logic [DIST_W-1:0]    dist_next [NEIGHBORS];
    logic [NIDX_W-1:0]    idx_reg [NEIGHBORS];
    logic [NIDX_W-1:0]    idx_next [NEIGHBORS];

    logic [NEIGHBORS-1:0] gt;
    logic [NEIGHBORS:0]   gt_ext;
    logic [NEIGHBORS-1:0] ins;

    // Slot p moves down when the candidate is strictly nearer or the slot is empty.
    // Equal distances stay ahead, so the lower index wins ties.
    always_comb
    begin
        for (int p = 0; p < NEIGHBORS; p++)
        begin
            gt[p] = !valid_reg[p] || (cand.sq_dist < dist_reg[p]);
        end
        gt_ext = {gt, 1'b0};
        for (int p = 0; p < NEIGHBORS; p++)
        begin
            ins[p] = gt[p] && !gt_ext[p];
        end
    end

    // Insert and shift
    always_comb
    begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        idx_next   = idx_reg;
        if (cand.valid)
        begin
            for (int p = 1; p < NEIGHBORS; p++)
            begin
                if (gt[p] && !ins[p])
                begin
                    valid_next[p] = valid_reg[p-1];
                    dist_next[p]  = dist_reg[p-1];
                    idx_next[p]   = idx_reg[p-1];
                end
            end
            for (int p = 0; p < NEIGHBORS; p++)
            begin
                if (ins[p])
                begin
                    valid_next[p] = 1'b1;
                    dist_next[p]  = cand.sq_dist;
                    idx_next[p]   = cand.idx;
                end
            end
        end
        if (clear)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        idx_reg  <= idx_next;
    end

    // Cutoff test 4*d2 < limit; the list is sorted so passing slots form a prefix
    always_comb
    begin
        for (int p = 0; p < NEIGHBORS; p++)
        begin
            pass[p] = valid_reg[p] && ({dist_reg[p], 2'b00} < limit);
            idx[p]  = idx_reg[p];
        end
    end

endmodule

// File: hdl/radius_limited_knn_graph.sv
// Radius-limited nearest-neighbor readout over a store of MAX_NODES 3-D node
// positions (signed 16-bit coordinates). A load word (op=0) writes one position
// and gives no result. A query word (op=1) reads the queried node, then streams
// every node in use (min(node_count, MAX_NODES)) through a pipelined
// squared-distance unit, one node per cycle at the rate of the single store read
// port, keeping the NEIGHBORS nearest in a sorted list (ties to the lower index,
// the queried node skipped). Those whose distance is under 1.5 * node_spacing
// come out nearest first, one word per cycle while rsp does not stall, with last
// set on the final one; a query with no such neighbor or an out-of-range index
// gives one word with found=0. A query holds cmd off until its last word has
// been issued (longer while rsp stalls), and an in-range query's first word
// appears only after the scan has drained. Write configuration only while the
// block is idle; writes are not held off during a query.
module radius_limited_knn_graph import rlkg_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int NEIGHBORS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rlkg_cmd_if.sink              cmd,
    rlkg_rsp_if.source            rsp
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int PW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int CAP = (MAX_NODES < 2047) ? MAX_NODES : 2047;
    localparam logic [COUNT_W-1:0] CAP_V = COUNT_W'(CAP);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SELF  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_JUDGE = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [SPACE_W-1:0]   spacing_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [NIDX_W-1:0]    qidx_reg, qidx_next;
    logic [COUNT_W-1:0]   used_reg, used_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [NEIGHBORS-1:0] pass_reg, pass_next;
    logic [PW-1:0]        ptr_reg, ptr_next;
    logic                 s0_valid_reg;
    logic [NIDX_W-1:0]    s0_idx_reg;
    logic [2*SPACE_W-1:0] sq_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [NIDX_W-1:0]    rsp_idx_reg, rsp_idx_next;
    logic                 rsp_found_reg, rsp_found_next;
    logic                 rsp_last_reg, rsp_last_next;

    logic                 cmd_acc, is_query, in_range, load_en;
    logic [COUNT_W-1:0]   used_now;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    pos_t                 wr_data, rd_data;
    cand_t                cand;
    logic [NIDX_W-1:0]    list_idx [NEIGHBORS];
    logic [NEIGHBORS-1:0] list_pass;
    logic [NEIGHBORS:0]   pass_shift;
    logic                 out_free, emit_last;

    // Command decode
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign is_query  = (cmd.op == OP_QUERY);
    assign used_now  = (count_reg < CAP_V) ? count_reg : CAP_V;
    assign in_range  = ({1'b0, cmd.node_index} < used_now);
    assign load_en   = cmd_acc && !is_query && (32'(cmd.node_index) < 32'(MAX_NODES));

    // Position store
    assign wr_data = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z};
    assign rd_en   = (state_reg == ST_SCAN) || (cmd_acc && is_query);
    assign rd_addr = (state_reg == ST_SCAN) ? AW'(cnt_reg) : AW'(cmd.node_index);

    rlkg_store #(
        .DEPTH (MAX_NODES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (AW'(cmd.node_index)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rlkg_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_self (state_reg == ST_SELF),
        .in_valid  (s0_valid_reg),
        .in_idx    (s0_idx_reg),
        .in_pos    (rd_data),
        .cand      (cand)
    );

    rlkg_list #(
        .NEIGHBORS (NEIGHBORS)
    ) u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (state_reg == ST_SELF),
        .cand  (cand),
        .limit (limit_reg),
        .idx   (list_idx),
        .pass  (list_pass)
    );

    // Emit bookkeeping
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign pass_shift = {1'b0, pass_reg} >> ptr_reg;
    assign emit_last  = !pass_reg[0] || !pass_shift[1];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        qidx_next      = qidx_reg;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        ptr_next       = ptr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_idx_next   = rsp_idx_reg;
        rsp_found_next = rsp_found_reg;
        rsp_last_next  = rsp_last_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && is_query)
                begin
                    qidx_next = cmd.node_index;
                    used_next = used_now;
                    pass_next = '0;
                    ptr_next  = '0;
                    state_next = in_range ? ST_SELF : ST_EMIT;
                end
            end
            ST_SELF:
            begin
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg == used_reg - COUNT_W'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == COUNT_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_JUDGE;
                end
                else
                begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            ST_JUDGE:
            begin
                pass_next  = list_pass;
                ptr_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_found_next = pass_reg[0];
                    rsp_idx_next   = pass_reg[0] ? list_idx[ptr_reg] : '0;
                    rsp_last_next  = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spacing_reg   <= '0;
            count_reg     <= COUNT_W'(1);
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            s0_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
            // Scan tag follows the read data; the queried node is dropped here
            s0_valid_reg  <= (state_reg == ST_SCAN) && (cnt_reg != {1'b0, qidx_reg});
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NODE_SPACING: spacing_reg <= cfg_data[SPACE_W-1:0];
                    REG_NODE_COUNT:   count_reg   <= cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        qidx_reg      <= qidx_next;
        used_reg      <= used_next;
        pass_reg      <= pass_next;
        s0_idx_reg    <= cnt_reg[NIDX_W-1:0];
        rsp_idx_reg   <= rsp_idx_next;
        rsp_found_reg <= rsp_found_next;
        rsp_last_reg  <= rsp_last_next;
        // Cutoff 9*s^2, built at query start: s^2 on acceptance, then 9*s^2 in ST_SELF
        if (cmd_acc && is_query)
        begin
            sq_reg <= spacing_reg * spacing_reg;
        end
        if (state_reg == ST_SELF)
        begin
            limit_reg <= LIMIT_W'({sq_reg, 3'b000}) + LIMIT_W'(sq_reg);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.neighbor_index = rsp_idx_reg;
    assign rsp.found          = rsp_found_reg;
    assign rsp.last           = rsp_last_reg;

endmodule

// File: test/testbench.sv
module testbench;
    import rlkg_pkg::*;

    localparam int MAX_NODES    = 1024;
    localparam int NEIGHBORS    = 8;
    localparam int RANDOM_ITEMS = 90;
    localparam int TAIL_CYCLES  = 4 * DRAIN_CYCLES + 16;
    localparam int CYCLE_LIMIT  = 2_000_000;

    // One result word as the block emits it
    typedef struct packed {
        logic [NIDX_W-1:0] neighbor_index;
        logic              found;
        logic              last;
    } nbr_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rlkg_cmd_if cmd_if ();
    rlkg_rsp_if rsp_if ();

    radius_limited_knn_graph #(
        .MAX_NODES (MAX_NODES),
        .NEIGHBORS (NEIGHBORS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .rsp       (rsp_if)
    );

    // Shadow copy of the node store and the registers
    pos_t               node_mem [MAX_NODES];
    logic [SPACE_W-1:0] spacing_reg = '0;
    logic [COUNT_W-1:0] count_reg   = COUNT_W'(1);

    nbr_word_t   neighbor_q [$];
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles    = 0;
    int unsigned cycle_count    = 0;
    nbr_word_t   got_word;
    nbr_word_t   exp_word;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got_word = '{rsp_if.neighbor_index, rsp_if.found, rsp_if.last};
            if (neighbor_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got idx=%0d found=%0b last=%0b",
                         $time, got_word.neighbor_index, got_word.found, got_word.last);
                mismatches++;
            end
            else
            begin
                exp_word = neighbor_q.pop_front();
                if (got_word.neighbor_index !== exp_word.neighbor_index)
                begin
                    $display("%0t: neighbor_index mismatch, expected %0d, got %0d",
                             $time, exp_word.neighbor_index, got_word.neighbor_index);
                    mismatches++;
                end
                if (got_word.found !== exp_word.found)
                begin
                    $display("%0t: found mismatch, expected %0b, got %0b",
                             $time, exp_word.found, got_word.found);
                    mismatches++;
                end
                if (got_word.last !== exp_word.last)
                begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, exp_word.last, got_word.last);
                    mismatches++;
                end
            end
        end
    end

    function automatic longint unsigned dist_sq(input int unsigned a, input int unsigned b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(node_mem[a].x)) - longint'($signed(node_mem[b].x));
        dy = longint'($signed(node_mem[a].y)) - longint'($signed(node_mem[b].y));
        dz = longint'($signed(node_mem[a].z)) - longint'($signed(node_mem[b].z));
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Append one expected word at the tail of the queue
    function automatic void add_expected(input nbr_word_t w);
        neighbor_q.insert(neighbor_q.size(), w);
    endfunction

    // Nearest-neighbor list of a query, filtered by the 1.5x spacing cutoff
    function automatic void predict_neighbors(input int unsigned qidx);
        int unsigned     used;
        longint unsigned best_d [NEIGHBORS];
        int unsigned     best_i [NEIGHBORS];
        longint unsigned d;
        longint unsigned cutoff;
        int              kept;
        int              emitted;
        int              p;
        int              q;
        used    = (int'(count_reg) < MAX_NODES) ? int'(count_reg) : MAX_NODES;
        kept    = 0;
        emitted = 0;
        if (qidx < used)
        begin
            // insertion sort, ties keep the lower index first
            for (int j = 0; j < used; j++)
            begin
                if (j == qidx)
                    continue;
                d = dist_sq(qidx, j);
                if (kept == NEIGHBORS && d >= best_d[NEIGHBORS-1])
                    continue;
                p = 0;
                while (p < kept && best_d[p] <= d)
                    p++;
                q = (kept < NEIGHBORS) ? kept : NEIGHBORS - 1;
                while (q > p)
                begin
                    best_d[q] = best_d[q-1];
                    best_i[q] = best_i[q-1];
                    q--;
                end
                best_d[p] = d;
                best_i[p] = j;
                if (kept < NEIGHBORS)
                    kept++;
            end
            cutoff = 64'd9 * 64'(spacing_reg) * 64'(spacing_reg);
            for (int k = 0; k < kept; k++)
            begin
                if (64'd4 * best_d[k] < cutoff)
                begin
                    add_expected('{NIDX_W'(best_i[k]), 1'b1, 1'b0});
                    emitted++;
                end
            end
        end
        if (emitted == 0)
            add_expected('{'0, 1'b0, 1'b1});
        else
            neighbor_q[neighbor_q.size()-1].last = 1'b1;
    endfunction

    // Clustered layout: 4x4 planes stacked in z, with optional jitter
    function automatic pos_t grid_pos(input int i, input int pitch, input int jit, input int base);
        int   c [3];
        pos_t p;
        c[0] = base + (i % 4) * pitch;
        c[1] = base + ((i / 4) % 4) * pitch;
        c[2] = base + (i / 16) * pitch;
        foreach (c[k])
        begin
            c[k] += int'($urandom_range(2 * jit)) - jit;
            if (c[k] > 32767)
                c[k] = 32767;
            else if (c[k] < -32768)
                c[k] = -32768;
        end
        p.x = COORD_W'(c[0]);
        p.y = COORD_W'(c[1]);
        p.z = COORD_W'(c[2]);
        return p;
    endfunction

    // Offer one word, wait for the handshake, then update the shadow model
    task automatic send_word(input logic op, input int unsigned idx, input pos_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.node_index <= NIDX_W'(idx);
        cmd_if.pos_x      <= p.x;
        cmd_if.pos_y      <= p.y;
        cmd_if.pos_z      <= p.z;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        if (op == OP_LOAD)
            node_mem[idx] = p;
        else
            predict_neighbors(idx);
    endtask

    task automatic wait_results_done();
        cmd_if.valid <= 1'b0;
        while (neighbor_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Idle the block fully: results drained and the scan pipeline empty
    task automatic settle();
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned spacing, input int unsigned count);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NODE_SPACING;
        cfg_data  <= CFG_DATA_W'(spacing);
        @(posedge clk);
        cfg_index <= REG_NODE_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_we <= 1'b0;
        spacing_reg = SPACE_W'(spacing);
        count_reg   = COUNT_W'(count);
        @(posedge clk);
    endtask

    // Reset values: one node in use, zero spacing
    task automatic test_reset_state();
        send_word(OP_LOAD, 0, '{-16'sd32768, 16'sd32767, 16'sd0});
        send_word(OP_QUERY, 0, '0);
        send_word(OP_QUERY, 1023, '0);
        settle();
    endtask

    // Hand-placed nodes: cutoff boundary, ties, zero distance, extreme coordinates
    task automatic test_directed_cases();
        pos_t pts [12];
        pts = '{
            '{16'sd0, 16'sd0, 16'sd0},
            '{16'sd100, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd150, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd149},
            '{16'sd0, 16'sd0, 16'sd0},
            '{-16'sd100, 16'sd0, 16'sd0},
            '{16'sd32767, 16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768, -16'sd32768},
            '{16'sd32767, -16'sd32768, 16'sd32767},
            '{-16'sd32768, 16'sd32767, -16'sd32768},
            '{16'sd50, 16'sd50, 16'sd50},
            '{-16'sd32768, -16'sd32768, -16'sd32767}
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(100, 12);
        foreach (pts[i])
            send_word(OP_LOAD, i, pts[i]);
        send_word(OP_LOAD, 1023, '{16'sd1, 16'sd2, 16'sd3});
        send_word(OP_QUERY, 0, '0);
        send_word(OP_QUERY, 5, '0);
        send_word(OP_QUERY, 7, '0);
        send_word(OP_QUERY, 12, '0);
        send_word(OP_QUERY, 1023, '0);
        settle();
        // widest cutoff, opposite corners of the coordinate range
        set_config(32767, 12);
        send_word(OP_QUERY, 6, '0);
        send_word(OP_QUERY, 0, '0);
        settle();
        // zero spacing: nothing passes, not even distance zero
        set_config(0, 12);
        send_word(OP_QUERY, 0, '0);
        settle();
        // no node in use
        set_config(100, 0);
        send_word(OP_QUERY, 0, '0);
        settle();
    endtask

    // Random phase: fill a clustered store, then mostly queries and moves
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int hold, input bit mid_pause);
        int unsigned used;
        int unsigned spacing;
        int          pitch;
        int          base;
        int          r;
        pos_t        p;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        used    = $urandom_range(48, 2);
        spacing = $urandom_range(1500, 40);
        pitch   = spacing * $urandom_range(160, 80) / 100;
        base    = int'($urandom_range(40000)) - 20000;
        set_config(spacing, used);
        for (int i = 0; i < used; i++)
            send_word(OP_LOAD, i, grid_pos(i, pitch, $urandom_range(1) * pitch / 3, base));
        hold_cycles = hold;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mid_pause && n == RANDOM_ITEMS / 2)
                wait_results_done();
            r = $urandom_range(99);
            if (r < 55)
                send_word(OP_QUERY, $urandom_range(used - 1), '0);
            else if (r < 65)
            begin
                // out of range query, random filler in the unused position fields
                p = '{COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom())};
                send_word(OP_QUERY, $urandom_range(1023, used), p);
            end
            else if (r < 90)
            begin
                r = $urandom_range(used - 1);
                send_word(OP_LOAD, r, grid_pos(r, pitch, $urandom_range(1) * pitch / 3, base));
            end
            else
            begin
                p = '{COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom())};
                send_word(OP_LOAD, $urandom_range(1023), p);
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_NODE_SPACING;
        cfg_data          <= '0;
        cmd_if.valid      <= 1'b0;
        cmd_if.op         <= OP_LOAD;
        cmd_if.node_index <= '0;
        cmd_if.pos_x      <= '0;
        cmd_if.pos_y      <= '0;
        cmd_if.pos_z      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_cases();
        test_random_phase(0, 0, 0, 1'b0);
        test_random_phase(47, 0, 0, 1'b1);
        test_random_phase(0, 47, 400, 1'b0);
        test_random_phase(25, 25, 0, 1'b0);

        if (neighbor_q.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, neighbor_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
hdl/rlkg_pkg.sv
hdl/rlkg_if.sv
hdl/rlkg_store.sv
hdl/rlkg_dist.sv
hdl/rlkg_list.sv
hdl/radius_limited_knn_graph.sv
test/testbench.sv
